>>> hdl/mmd_pkg.sv
// Shared types and constants for the multichannel min/max decimator.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package mmd_pkg;

    // default configuration of the top level
    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;

    // fixed field widths of the stream items
    localparam int FIELDS        = 8;
    localparam int PRESENT_BITS  = 8;
    localparam int HOP_BITS      = 16;
    localparam int TOTAL_BITS    = 48;
    localparam int PEAK_BITS     = 16;
    localparam int OUT_USER_BITS = 2;
    localparam int OUT_DATA_BITS = 2 * PEAK_BITS + TOTAL_BITS;

    // stretch length after reset
    localparam logic [HOP_BITS-1:0] HOP_RESET = 16'd256;

    // input item kinds carried on tuser
    typedef enum logic {
        CMD_FRAME  = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    // flags that travel with a result, packed as on the output tuser
    typedef struct packed {
        logic finished;
        logic pair_valid;
    } t_res_flags;

endpackage

>>> hdl/mmd_frame_reduce.sv
// Per-frame min/max of the present channels through a three-level compare tree.
// Depends on mmd_pkg.
`timescale 1ns / 1ps

module mmd_frame_reduce #(
    parameter int CHANNELS    = mmd_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic [mmd_pkg::PRESENT_BITS-1:0]                i_present,
    input  logic [mmd_pkg::FIELDS-1:0][SAMPLE_BITS-1:0]     i_samples,
    output logic                                            o_any,
    output logic signed [SAMPLE_BITS-1:0]                   o_low,
    output logic signed [SAMPLE_BITS-1:0]                   o_high
);

    localparam int LANES = (CHANNELS < mmd_pkg::FIELDS) ? CHANNELS : mmd_pkg::FIELDS;

    // lower of two candidates, either of which may be absent
    function automatic logic signed [SAMPLE_BITS-1:0] pick_low(
        input logic va, input logic signed [SAMPLE_BITS-1:0] a,
        input logic vb, input logic signed [SAMPLE_BITS-1:0] b);
        if (!vb) return a;
        if (!va) return b;
        return (b < a) ? b : a;
    endfunction

    // higher of two candidates, either of which may be absent
    function automatic logic signed [SAMPLE_BITS-1:0] pick_high(
        input logic va, input logic signed [SAMPLE_BITS-1:0] a,
        input logic vb, input logic signed [SAMPLE_BITS-1:0] b);
        if (!vb) return a;
        if (!va) return b;
        return (b > a) ? b : a;
    endfunction

    logic [7:0]                    l0_v;
    logic signed [SAMPLE_BITS-1:0] l0_x [8];
    logic [3:0]                    l1_v;
    logic signed [SAMPLE_BITS-1:0] l1_lo [4];
    logic signed [SAMPLE_BITS-1:0] l1_hi [4];
    logic [1:0]                    l2_v;
    logic signed [SAMPLE_BITS-1:0] l2_lo [2];
    logic signed [SAMPLE_BITS-1:0] l2_hi [2];

    // leaves: channels beyond the configured count never take part
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            l0_v[i] = i_present[i] && (i < LANES);
            l0_x[i] = $signed(i_samples[i]);
        end
    end

    // pairwise merge, three levels
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            l1_v[i]  = l0_v[2*i] | l0_v[2*i+1];
            l1_lo[i] = pick_low(l0_v[2*i], l0_x[2*i], l0_v[2*i+1], l0_x[2*i+1]);
            l1_hi[i] = pick_high(l0_v[2*i], l0_x[2*i], l0_v[2*i+1], l0_x[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            l2_v[i]  = l1_v[2*i] | l1_v[2*i+1];
            l2_lo[i] = pick_low(l1_v[2*i], l1_lo[2*i], l1_v[2*i+1], l1_lo[2*i+1]);
            l2_hi[i] = pick_high(l1_v[2*i], l1_hi[2*i], l1_v[2*i+1], l1_hi[2*i+1]);
        end
        o_any  = l2_v[0] | l2_v[1];
        o_low  = pick_low(l2_v[0], l2_lo[0], l2_v[1], l2_lo[1]);
        o_high = pick_high(l2_v[0], l2_hi[0], l2_v[1], l2_hi[1]);
    end

endmodule

>>> hdl/mmd_tracker.sv
// Stretch state (running extremes, fill, frame count, hop length) and raw result register.
// Depends on mmd_pkg.
`timescale 1ns / 1ps

module mmd_tracker #(
    parameter int SAMPLE_BITS = mmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [mmd_pkg::HOP_BITS-1:0]         i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_cmd,
    input  logic                                 i_any,
    input  logic signed [SAMPLE_BITS-1:0]        i_low,
    input  logic signed [SAMPLE_BITS-1:0]        i_high,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output mmd_pkg::t_res_flags                  o_flags,
    output logic signed [SAMPLE_BITS-1:0]        o_low,
    output logic signed [SAMPLE_BITS-1:0]        o_high,
    output logic [mmd_pkg::TOTAL_BITS-1:0]       o_total
);

    logic [mmd_pkg::HOP_BITS-1:0]   r_hop;
    logic signed [SAMPLE_BITS-1:0]  r_low;
    logic signed [SAMPLE_BITS-1:0]  r_high;
    logic [mmd_pkg::HOP_BITS-1:0]   r_fill;
    logic [mmd_pkg::TOTAL_BITS-1:0] r_frames;

    logic signed [SAMPLE_BITS-1:0]  n_low;
    logic signed [SAMPLE_BITS-1:0]  n_high;
    logic [mmd_pkg::HOP_BITS-1:0]   n_fill;
    logic [mmd_pkg::TOTAL_BITS-1:0] n_frames;
    logic [mmd_pkg::HOP_BITS:0]     fill_inc;

    logic                           res_hit;
    mmd_pkg::t_res_flags            res_flags;
    logic signed [SAMPLE_BITS-1:0]  res_low;
    logic signed [SAMPLE_BITS-1:0]  res_high;

    logic                           r_res_valid;
    mmd_pkg::t_res_flags            r_res_flags;
    logic signed [SAMPLE_BITS-1:0]  r_res_low;
    logic signed [SAMPLE_BITS-1:0]  r_res_high;
    logic [mmd_pkg::TOTAL_BITS-1:0] r_res_total;

    logic                           fire;

    assign o_ready = !r_res_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // next stretch state and the result this item causes
    always_comb begin
        n_low     = r_low;
        n_high    = r_high;
        n_fill    = r_fill;
        n_frames  = r_frames;
        res_hit   = 1'b0;
        res_flags = '0;
        fill_inc  = {1'b0, r_fill} + 1'b1;
        if (i_cmd == mmd_pkg::CMD_FINISH) begin
            res_hit              = 1'b1;
            res_flags.finished   = 1'b1;
            res_flags.pair_valid = (r_fill != '0);
            n_fill               = '0;
        end else begin
            if (i_any) begin
                if (r_fill == '0) begin
                    n_low  = i_low;
                    n_high = i_high;
                end else begin
                    n_low  = (i_low < r_low) ? i_low : r_low;
                    n_high = (i_high > r_high) ? i_high : r_high;
                end
            end
            if (r_frames != '1) begin
                n_frames = r_frames + 1'b1;
            end
            if (fill_inc >= {1'b0, r_hop}) begin
                res_hit              = 1'b1;
                res_flags.pair_valid = 1'b1;
                n_fill               = '0;
            end else begin
                n_fill = fill_inc[mmd_pkg::HOP_BITS-1:0];
            end
        end
        res_low  = n_low;
        res_high = n_high;
    end

    // hop length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop <= mmd_pkg::HOP_RESET;
        end else if (i_cfg_wr_en) begin
            r_hop <= i_cfg_wr_data;
        end
    end

    // stretch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= '0;
            r_high   <= '0;
            r_fill   <= '0;
            r_frames <= '0;
        end else if (fire) begin
            r_low    <= n_low;
            r_high   <= n_high;
            r_fill   <= n_fill;
            r_frames <= n_frames;
        end
    end

    // raw result register, valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_ready) begin
            r_res_valid <= fire && res_hit;
        end
    end

    // raw result register, payload
    always_ff @(posedge i_clk) begin
        if (fire && res_hit) begin
            r_res_flags <= res_flags;
            r_res_low   <= res_low;
            r_res_high  <= res_high;
            r_res_total <= n_frames;
        end
    end

    assign o_valid = r_res_valid;
    assign o_flags = r_res_flags;
    assign o_low   = r_res_low;
    assign o_high  = r_res_high;
    assign o_total = r_res_total;

endmodule

>>> hdl/mmd_convert.sv
// Output register: clamp, scale by 32767 and round the extremes to 16 bits.
// Depends on mmd_pkg.
`timescale 1ns / 1ps

module mmd_convert #(
    parameter int SAMPLE_BITS = mmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  mmd_pkg::t_res_flags                       i_flags,
    input  logic signed [SAMPLE_BITS-1:0]             i_low,
    input  logic signed [SAMPLE_BITS-1:0]             i_high,
    input  logic [mmd_pkg::TOTAL_BITS-1:0]            i_total,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [mmd_pkg::OUT_DATA_BITS-1:0]         o_data,
    output logic [mmd_pkg::OUT_USER_BITS-1:0]         o_user
);

    localparam int PB        = mmd_pkg::PEAK_BITS;
    localparam int SHIFT     = PB - 1;
    localparam int PROD_BITS = SAMPLE_BITS - 1 + SHIFT;
    localparam logic [SAMPLE_BITS-1:0] UNIT = {2'b01, {(SAMPLE_BITS-2){1'b0}}};
    localparam logic [PROD_BITS-1:0]   HALF = PROD_BITS'(UNIT >> 1);

    // |v| clamped to 1.0, times (2^15 - 1), plus one half, back to integer
    function automatic logic [PB-1:0] to_peak(input logic signed [SAMPLE_BITS-1:0] v);
        logic                   neg;
        logic [SAMPLE_BITS-1:0] mag_full;
        logic [SAMPLE_BITS-2:0] mag;
        logic [PROD_BITS-1:0]   prod;
        logic [PB-1:0]          r;
        neg      = v[SAMPLE_BITS-1];
        mag_full = neg ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
        mag      = (mag_full > UNIT) ? UNIT[SAMPLE_BITS-2:0] : mag_full[SAMPLE_BITS-2:0];
        prod     = {mag, {SHIFT{1'b0}}} - PROD_BITS'(mag) + HALF;
        r        = prod[PROD_BITS-1 -: PB];
        return neg ? PB'(-r) : r;
    endfunction

    logic                          r_out_valid;
    mmd_pkg::t_res_flags           r_out_flags;
    logic [PB-1:0]                 r_out_low;
    logic [PB-1:0]                 r_out_high;
    logic [mmd_pkg::TOTAL_BITS-1:0] r_out_total;

    assign o_ready = !r_out_valid || i_ready;

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // output payload; a finish on an empty stretch reports zeros
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_out_flags <= i_flags;
            r_out_low   <= i_flags.pair_valid ? to_peak(i_low) : '0;
            r_out_high  <= i_flags.pair_valid ? to_peak(i_high) : '0;
            r_out_total <= i_total;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {r_out_total, r_out_high, r_out_low};
    assign o_user  = r_out_flags;

endmodule

>>> hdl/multichannel_min_max_decimator.sv
// Top level of the multichannel min/max decimator: input register and stage wiring.
// Depends on mmd_pkg, mmd_frame_reduce, mmd_tracker and mmd_convert.
//
//  port group  | dir | tdata (low bit first)                         | tuser
//  ------------+-----+-----------------------------------------------+------------------------
//  s_axis      | in  | channel_present[7:0], sample_0 .. sample_7    | command
//  m_axis      | out | peak_low[15:0], peak_high[15:0], frame_total  | pair_valid, finished
//  i_cfg_wr_*  | in  | hop_length[15:0]                              | -
//
// One item per cycle sustained while m_axis_tready stays high; an item passes on to its result through
// the three registers in line (input, raw result, converted output).
// Reset is synchronous and active low: hop_length 256, stretch and frame count zero,
// no clearing pass. When m_axis_tready is low the three registers fill up and
// s_axis_tready drops once all of them hold an item.
`timescale 1ns / 1ps

module multichannel_min_max_decimator #(
    parameter int CHANNELS    = mmd_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_wr_en,
    input  logic [mmd_pkg::HOP_BITS-1:0]                  i_cfg_wr_data,  // hop_length
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // channel_present, sample_0 .. sample_7, zero fill to whole bytes
    input  logic [((mmd_pkg::PRESENT_BITS + mmd_pkg::FIELDS * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                                          s_axis_tdata,
    input  logic                                          s_axis_tuser,   // command
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // peak_low, peak_high, frame_total
    output logic [mmd_pkg::OUT_DATA_BITS-1:0]             m_axis_tdata,
    // pair_valid, finished
    output logic [mmd_pkg::OUT_USER_BITS-1:0]             m_axis_tuser
);

    localparam int IN_DATA_BITS =
        ((mmd_pkg::PRESENT_BITS + mmd_pkg::FIELDS * SAMPLE_BITS + 7) / 8) * 8;

    logic                          r_in_valid;
    logic                          r_in_cmd;
    logic [IN_DATA_BITS-1:0]       r_in_data;

    logic                          trk_ready;
    logic                          red_any;
    logic signed [SAMPLE_BITS-1:0] red_low;
    logic signed [SAMPLE_BITS-1:0] red_high;

    logic                          res_valid;
    logic                          cnv_ready;
    mmd_pkg::t_res_flags           res_flags;
    logic signed [SAMPLE_BITS-1:0] res_low;
    logic signed [SAMPLE_BITS-1:0] res_high;
    logic [mmd_pkg::TOTAL_BITS-1:0] res_total;

    logic [mmd_pkg::FIELDS-1:0][SAMPLE_BITS-1:0] in_samples;

    assign s_axis_tready = !r_in_valid || trk_ready;

    // input register, valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // input register, payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
    end

    assign in_samples =
        r_in_data[mmd_pkg::PRESENT_BITS +: mmd_pkg::FIELDS * SAMPLE_BITS];

    // frame min/max over present channels
    mmd_frame_reduce #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_reduce (
        .i_present (r_in_data[mmd_pkg::PRESENT_BITS-1:0]),
        .i_samples (in_samples),
        .o_any     (red_any),
        .o_low     (red_low),
        .o_high    (red_high)
    );

    // stretch state and raw result
    mmd_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (r_in_valid),
        .o_ready       (trk_ready),
        .i_cmd         (r_in_cmd),
        .i_any         (red_any),
        .i_low         (red_low),
        .i_high        (red_high),
        .o_valid       (res_valid),
        .i_ready       (cnv_ready),
        .o_flags       (res_flags),
        .o_low         (res_low),
        .o_high        (res_high),
        .o_total       (res_total)
    );

    // 16-bit conversion and output register
    mmd_convert #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (cnv_ready),
        .i_flags (res_flags),
        .i_low   (res_low),
        .i_high  (res_high),
        .i_total (res_total),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

endmodule

>>> hdl/mmd_checker.sv
// Port-level checks on the result stream of the decimator, bound to the top level.
// Depends on mmd_pkg and multichannel_min_max_decimator.
`timescale 1ns / 1ps

module mmd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mmd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [mmd_pkg::OUT_USER_BITS-1:0] m_axis_tuser
);

    localparam int PB = mmd_pkg::PEAK_BITS;

    mmd_pkg::t_res_flags  flags;
    logic signed [PB-1:0] peak_low;
    logic signed [PB-1:0] peak_high;

    assign flags     = m_axis_tuser;
    assign peak_low  = m_axis_tdata[PB-1:0];
    assign peak_high = m_axis_tdata[2*PB-1:PB];

    // a stalled result keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // only a finish may report an empty stretch
    a_full_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !flags.finished |-> flags.pair_valid)
        else $error("full stretch without a pair");

    // an empty stretch reports zero extremes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !flags.pair_valid |-> peak_low == '0 && peak_high == '0)
        else $error("empty stretch with nonzero peaks");

    // converted pair is ordered and never reaches the most negative code
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && flags.pair_valid |->
            peak_low <= peak_high && peak_low != {1'b1, {(PB-1){1'b0}}})
        else $error("peak pair out of order or out of range");

endmodule

bind multichannel_min_max_decimator mmd_checker u_mmd_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the multichannel min/max decimator.
// Depends on mmd_pkg and the multichannel_min_max_decimator top level in hdl/.
`timescale 1ns / 1ps

module tb_top;

    localparam int     SB       = mmd_pkg::SAMPLE_BITS_DEF;
    localparam int     CH       = mmd_pkg::CHANNELS_DEF;
    localparam int     DW       =
        ((mmd_pkg::PRESENT_BITS + mmd_pkg::FIELDS * SB + 7) / 8) * 8;
    localparam int     FRAC     = SB - 2;
    localparam longint UNIT     = longint'(1) << FRAC;
    localparam int     N_RANDOM = 600;
    localparam int     HOLD_OFF = 8;
    localparam int     N_DIR    = 24;

    // handy sample values
    localparam logic signed [SB-1:0] SZ   = '0;
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] S1   = SB'(UNIT);
    localparam logic signed [SB-1:0] SH   = SB'(UNIT / 2);
    localparam logic signed [SB-1:0] SHN  = -SH;
    localparam logic signed [SB-1:0] SOVR = S1 + 1;
    localparam logic signed [SB-1:0] SUND = -S1 - 1;

    // one result as it leaves the block
    typedef struct packed {
        logic                                 pair_valid;
        logic signed [mmd_pkg::PEAK_BITS-1:0] peak_low;
        logic signed [mmd_pkg::PEAK_BITS-1:0] peak_high;
        logic                                 finished;
        logic [mmd_pkg::TOTAL_BITS-1:0]       frame_total;
    } t_peak;

    localparam t_peak NONE = '0;

    // one input item
    typedef struct {
        mmd_pkg::t_cmd                    cmd;
        logic [mmd_pkg::PRESENT_BITS-1:0] present;
        logic signed [SB-1:0]             samp [mmd_pkg::FIELDS];
    } t_item;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_HOP  = 1'b1
    } t_row_kind;

    // directed row: channel 0 gets s_first, 1..6 s_mid, 7 s_last
    typedef struct {
        t_row_kind                        kind;
        mmd_pkg::t_cmd                    cmd;
        logic [mmd_pkg::PRESENT_BITS-1:0] present;
        logic signed [SB-1:0]             s_first;
        logic signed [SB-1:0]             s_mid;
        logic signed [SB-1:0]             s_last;
        logic [mmd_pkg::HOP_BITS-1:0]     hop;
        bit                               typed;
        t_peak                            exp;
    } t_row;

    // directed stimulus table
    t_row dir_tab [N_DIR] = '{
        // finish on an empty stretch right after reset
        '{ROW_ITEM, mmd_pkg::CMD_FINISH, 8'h00, SZ, SZ, SZ, 16'd0, 1'b1,
          '{1'b0, 16'sd0, 16'sd0, 1'b1, 48'd0}},
        // empty first frame keeps the old extremes, then one frame merges
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h00, SZ, SZ, SZ, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h01, SMAX, SMIN, SMIN, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FINISH, 8'h00, SZ, SZ, SZ, 16'd0, 1'b1,
          '{1'b1, 16'sd0, 16'sd32767, 1'b1, 48'd2}},
        // full scale on every channel
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'hFF, SMIN, SZ, SMAX, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FINISH, 8'hFF, SMAX, SMAX, SMAX, 16'd0, 1'b1,
          '{1'b1, -16'sd32767, 16'sd32767, 1'b1, 48'd3}},
        // absent channels carry junk that must be ignored
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h80, SMIN, SMIN, S1, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FINISH, 8'h00, SZ, SZ, SZ, 16'd0, 1'b1,
          '{1'b1, 16'sd32767, 16'sd32767, 1'b1, 48'd4}},
        // half scale rounds away from zero
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h03, SH, SHN, SZ, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FINISH, 8'h00, SZ, SZ, SZ, 16'd0, 1'b1,
          '{1'b1, -16'sd16384, 16'sd16384, 1'b1, 48'd5}},
        // second finish in a row finds nothing to flush
        '{ROW_ITEM, mmd_pkg::CMD_FINISH, 8'h00, SZ, SZ, SZ, 16'd0, 1'b1,
          '{1'b0, 16'sd0, 16'sd0, 1'b1, 48'd5}},
        // one frame per stretch
        '{ROW_HOP,  mmd_pkg::CMD_FRAME,  8'h00, SZ, SZ, SZ, 16'd1, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h01, 24'sd1, SZ, SZ, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h7E, SZ, -24'sd1, SZ, 16'd0, 1'b0, NONE},
        // zero stretch length behaves as one; clamping beyond full scale
        '{ROW_HOP,  mmd_pkg::CMD_FRAME,  8'h00, SZ, SZ, SZ, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'hFF, SOVR, SUND, 24'sd12345, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h00, SMAX, SMAX, SMAX, 16'd0, 1'b0, NONE},
        // longest stretch, then shortened below the current fill
        '{ROW_HOP,  mmd_pkg::CMD_FRAME,  8'h00, SZ, SZ, SZ, 16'hFFFF, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h55, -24'sd3, 24'sd77777, SZ, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'hAA, SMAX, 24'sd5, SMIN, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h0F, SZ, SH, SZ, 16'd0, 1'b0, NONE},
        '{ROW_HOP,  mmd_pkg::CMD_FRAME,  8'h00, SZ, SZ, SZ, 16'd2, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FRAME,  8'h00, SZ, SZ, SZ, 16'd0, 1'b0, NONE},
        '{ROW_ITEM, mmd_pkg::CMD_FINISH, 8'h00, SZ, SZ, SZ, 16'd0, 1'b0, NONE}
    };

    // dut signals
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_wr_en   = 1'b0;
    logic [mmd_pkg::HOP_BITS-1:0]        i_cfg_wr_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [DW-1:0]                       s_axis_tdata  = '0;
    logic                                s_axis_tuser  = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [mmd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;
    logic [mmd_pkg::OUT_USER_BITS-1:0]   m_axis_tuser;

    // predicted decimator state
    logic [mmd_pkg::HOP_BITS-1:0]   pr_hop    = mmd_pkg::HOP_RESET;
    longint                         pr_low    = 0;
    longint                         pr_high   = 0;
    int                             pr_fill   = 0;
    logic [mmd_pkg::TOTAL_BITS-1:0] pr_frames = '0;

    t_peak peak_q [$];
    t_peak mon_exp;
    mmd_pkg::t_res_flags mon_flags;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int n_err    = 0;
    int n_items  = 0;
    int n_pairs  = 0;
    int n_finish = 0;
    int n_hops   = 0;

    multichannel_min_max_decimator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // clamp to full scale, scale to 16 bits, round half away from zero
    function automatic logic signed [mmd_pkg::PEAK_BITS-1:0] to_peak(input longint v);
        longint m;
        bit     neg;
        neg = v < 0;
        m = neg ? -v : v;
        if (m > UNIT) m = UNIT;
        m = (m * 32767 + UNIT / 2) >>> FRAC;
        return mmd_pkg::PEAK_BITS'(neg ? -m : m);
    endfunction

    // advance the predicted state by one item; returns 1 when a result follows
    function automatic bit step_decimator(input t_item it, output t_peak res);
        bit     starting;
        int     nxt;
        longint v;
        res = '0;
        if (it.cmd == mmd_pkg::CMD_FINISH) begin
            res.pair_valid  = pr_fill != 0;
            if (res.pair_valid) begin
                res.peak_low  = to_peak(pr_low);
                res.peak_high = to_peak(pr_high);
            end
            res.finished    = 1'b1;
            res.frame_total = pr_frames;
            pr_fill = 0;
            return 1'b1;
        end
        starting = pr_fill == 0;
        for (int c = 0; c < CH && c < mmd_pkg::FIELDS; c++) begin
            if (it.present[c]) begin
                v = longint'(it.samp[c]);
                if (starting) begin
                    pr_low   = v;
                    pr_high  = v;
                    starting = 1'b0;
                end else begin
                    if (v < pr_low)  pr_low  = v;
                    if (v > pr_high) pr_high = v;
                end
            end
        end
        if (pr_frames != '1) pr_frames = pr_frames + 1'b1;
        nxt = pr_fill + 1;
        if (nxt >= int'(pr_hop)) begin
            res.pair_valid  = 1'b1;
            res.peak_low    = to_peak(pr_low);
            res.peak_high   = to_peak(pr_high);
            res.frame_total = pr_frames;
            pr_fill = 0;
            return 1'b1;
        end
        pr_fill = nxt & 16'hFFFF;
        return 1'b0;
    endfunction

    // random sample, weighted toward full scale and the clamp boundary
    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SMAX;
            1:       return SMIN;
            2:       return S1 + SB'($urandom_range(0, 2)) - SB'(1);
            3:       return SB'(-UNIT) + SB'($urandom_range(0, 2)) - SB'(1);
            4:       return SB'($urandom_range(0, 200)) - SB'(100);
            default: return SB'($urandom());
        endcase
    endfunction

    // drive one item, wait for its transfer, then record what it should yield
    task automatic send_item(input t_item it, input bit typed, input t_peak typed_exp);
        int            gap;
        logic [DW-1:0] d;
        t_peak         p;
        bit            has;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        d = '0;
        d[mmd_pkg::PRESENT_BITS-1:0] = it.present;
        for (int c = 0; c < mmd_pkg::FIELDS; c++) begin
            d[mmd_pkg::PRESENT_BITS + c * SB +: SB] = it.samp[c];
        end
        s_axis_tdata  <= d;
        s_axis_tuser  <= it.cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        has = step_decimator(it, p);
        if (has) begin
            if (typed) p = typed_exp;
            peak_q = {peak_q, p};
        end
        n_items++;
        if (it.cmd == mmd_pkg::CMD_FINISH) n_finish++;
    endtask

    // wait until the block has drained, including items that yield nothing
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (peak_q.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    // change the stretch length while idle
    task automatic write_hop(input logic [mmd_pkg::HOP_BITS-1:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pr_hop = v;
        n_hops++;
    endtask

    // result side: random stall before each transfer
    initial begin
        int w;
        forever begin
            w = rx_calm ? 0 : $urandom_range(0, 16);
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_flags = m_axis_tuser;
            if (peak_q.size() == 0) begin
                $error("result with nothing expected: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                n_err++;
            end else begin
                mon_exp = peak_q.pop_front();
                n_pairs++;
                if (mon_flags.pair_valid !== mon_exp.pair_valid) begin
                    $error("pair_valid: expected %0d, got %0d",
                           mon_exp.pair_valid, mon_flags.pair_valid);
                    n_err++;
                end
                if ($signed(m_axis_tdata[15:0]) !== mon_exp.peak_low) begin
                    $error("peak_low: expected %0d, got %0d",
                           mon_exp.peak_low, $signed(m_axis_tdata[15:0]));
                    n_err++;
                end
                if ($signed(m_axis_tdata[31:16]) !== mon_exp.peak_high) begin
                    $error("peak_high: expected %0d, got %0d",
                           mon_exp.peak_high, $signed(m_axis_tdata[31:16]));
                    n_err++;
                end
                if (mon_flags.finished !== mon_exp.finished) begin
                    $error("finished: expected %0d, got %0d",
                           mon_exp.finished, mon_flags.finished);
                    n_err++;
                end
                if (m_axis_tdata[79:32] !== mon_exp.frame_total) begin
                    $error("frame_total: expected %0d, got %0d",
                           mon_exp.frame_total, m_axis_tdata[79:32]);
                    n_err++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_item it;
        int    n_rand;
        int    n;
        int    r;
        int    k;
        logic [mmd_pkg::HOP_BITS-1:0] hop;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_HOP) begin
                write_hop(dir_tab[i].hop);
            end else begin
                it.cmd     = dir_tab[i].cmd;
                it.present = dir_tab[i].present;
                it.samp[0] = dir_tab[i].s_first;
                for (int c = 1; c < mmd_pkg::FIELDS - 1; c++) it.samp[c] = dir_tab[i].s_mid;
                it.samp[mmd_pkg::FIELDS-1] = dir_tab[i].s_last;
                send_item(it, dir_tab[i].typed, dir_tab[i].exp);
            end
        end

        // random phases, each with its own stretch length
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            r = $urandom_range(0, 19);
            if (r == 0)      hop = '0;
            else if (r == 1) hop = '1;
            else if (r < 5)  hop = mmd_pkg::HOP_BITS'($urandom_range(9, 60));
            else             hop = mmd_pkg::HOP_BITS'($urandom_range(1, 8));
            write_hop(hop);
            tx_calm = $urandom_range(0, 3) == 0;
            rx_calm = $urandom_range(0, 3) == 0;
            n = $urandom_range(8, 48);
            for (k = 0; k < n; k++) begin
                it.cmd = ($urandom_range(0, 19) == 0) ? mmd_pkg::CMD_FINISH
                                                      : mmd_pkg::CMD_FRAME;
                case ($urandom_range(0, 7))
                    0:       it.present = '0;
                    1:       it.present = '1;
                    default: it.present = mmd_pkg::PRESENT_BITS'($urandom());
                endcase
                for (int c = 0; c < mmd_pkg::FIELDS; c++) it.samp[c] = rand_sample();
                send_item(it, 1'b0, NONE);
                n_rand++;
            end
            // half the phases close with a flush, the rest leave a partial stretch
            if ($urandom_range(0, 1) == 1) begin
                it.cmd = mmd_pkg::CMD_FINISH;
                send_item(it, 1'b0, NONE);
                n_rand++;
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        k = 0;
        while (peak_q.size() != 0 && k < 5000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (HOLD_OFF) @(posedge i_clk);
        if (peak_q.size() != 0) begin
            $error("%0d expected results never arrived", peak_q.size());
            n_err += peak_q.size();
        end

        $display("sent %0d items (%0d finish commands) over %0d stretch lengths",
                 n_items, n_finish, n_hops);
        $display("checked %0d results, %0d mismatches", n_pairs, n_err);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", peak_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
